/* sv/bba_pkg.sv */
// bba_pkg: payload structs, result codes, controller states and the
// command/status groups shared by the buddy allocator modules.
// No dependencies.
package bba_pkg;

   typedef struct packed {
      logic        command;
      logic [15:0] request_size;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_address;
   } rsp_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_A_RD,
      S_A_EVAL,
      S_A_SPLIT,
      S_A_BACK,
      S_F_RD,
      S_F_EVAL,
      S_M_CHECK,
      S_M_EVAL,
      S_M_JOIN,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      FIN_ALLOC_OK,
      FIN_FREE_OK,
      FIN_NO_SPACE,
      FIN_BAD_ADDR
   } fin_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    clr_step;
      logic    rd_lo;
      logic    rd_buddy;
      logic    wr_take;
      logic    wr_split_lo;
      logic    wr_split_mid;
      logic    down;
      logic    back_sib;
      logic    back_up;
      logic    free_idx;
      logic    wr_unmark;
      logic    wr_hi;
      logic    wr_lo;
      logic    finish;
      fin_type fin;
      logic    rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic is_free;
      logic too_big;
      logic free_bad;
      logic take;
      logic split;
      logic go_down;
      logic at_root;
      logic is_left;
      logic entry_zero;
      logic merge_go;
      logic buddy_eq;
      logic rsp_busy;
   } stat_type;

endpackage

/* sv/buddy_block_allocator.sv */
// Buddy allocator over a HEAP_BYTES heap in MIN_BLOCK units. One item at a
// time; the block table is a memory of ENTRIES entries with one write and one
// read port. On allocate each tree node visited is read, then decided on; a
// split adds a write step, a backtrack is one step. A free reads and unmarks
// its entry, then per merged level reads, compares and joins the buddy. The
// result then moves to the output register once it is free; that register
// holds it while the next item is taken. After reset a clearing pass writes
// every table entry with req_ready low; csr writes are accepted at any time.
module buddy_block_allocator #(
   parameter int HEAP_BYTES = 16384,
   parameter int MIN_BLOCK  = 32,
   parameter int ENTRIES    = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import bba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_datapath #(
      .HEAP_BYTES (HEAP_BYTES),
      .MIN_BLOCK  (MIN_BLOCK),
      .ENTRIES    (ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sv/bba_ctrl.sv */
// bba_ctrl: sequencer for the buddy allocator: table clearing, depth-first
// allocate walk with backtracking, free and buddy merge.
// Depends on bba_pkg.
module bba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bba_pkg::stat_type stat,
   output bba_pkg::cmd_type  cmd
);
   import bba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_START;
         end
         S_START: begin
            if (stat.is_free) begin
               state_in = stat.free_bad ? S_DONE : S_F_RD;
            end else begin
               state_in = stat.too_big ? S_DONE : S_A_RD;
            end
         end
         S_A_RD:    state_in = S_A_EVAL;
         S_A_EVAL: begin
            if (stat.take)         state_in = S_DONE;
            else if (stat.split)   state_in = S_A_SPLIT;
            else if (stat.go_down) state_in = S_A_RD;
            else                   state_in = S_A_BACK;
         end
         S_A_SPLIT: state_in = S_A_RD;
         S_A_BACK: begin
            if (stat.at_root)      state_in = S_DONE;
            else if (stat.is_left) state_in = S_A_RD;
         end
         S_F_RD:    state_in = S_F_EVAL;
         S_F_EVAL: begin
            state_in = stat.entry_zero ? S_DONE : S_M_CHECK;
         end
         S_M_CHECK: begin
            state_in = stat.merge_go ? S_M_EVAL : S_DONE;
         end
         S_M_EVAL: begin
            state_in = stat.buddy_eq ? S_M_JOIN : S_DONE;
         end
         S_M_JOIN:  state_in = S_M_CHECK;
         S_DONE: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default:   state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clr_step = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_START: begin
            if (stat.is_free) begin
               if (stat.free_bad) begin
                  cmd.finish = 1'b1;
                  cmd.fin    = FIN_BAD_ADDR;
               end else begin
                  cmd.free_idx = 1'b1;
               end
            end else if (stat.too_big) begin
               cmd.finish = 1'b1;
               cmd.fin    = FIN_NO_SPACE;
            end
         end
         S_A_RD: cmd.rd_lo = 1'b1;
         S_A_EVAL: begin
            if (stat.take) begin
               cmd.wr_take = 1'b1;
               cmd.finish  = 1'b1;
               cmd.fin     = FIN_ALLOC_OK;
            end else if (stat.split) begin
               cmd.wr_split_lo = 1'b1;
            end else if (stat.go_down) begin
               cmd.down = 1'b1;
            end
         end
         S_A_SPLIT: cmd.wr_split_mid = 1'b1;
         S_A_BACK: begin
            if (stat.at_root) begin
               cmd.finish = 1'b1;
               cmd.fin    = FIN_NO_SPACE;
            end else if (stat.is_left) begin
               cmd.back_sib = 1'b1;
            end else begin
               cmd.back_up = 1'b1;
            end
         end
         S_F_RD: cmd.rd_lo = 1'b1;
         S_F_EVAL: begin
            if (stat.entry_zero) begin
               cmd.finish = 1'b1;
               cmd.fin    = FIN_BAD_ADDR;
            end else begin
               cmd.wr_unmark = 1'b1;
            end
         end
         S_M_CHECK: begin
            if (stat.merge_go) begin
               cmd.rd_buddy = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               cmd.fin    = FIN_FREE_OK;
            end
         end
         S_M_EVAL: begin
            if (stat.buddy_eq) begin
               cmd.wr_hi = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               cmd.fin    = FIN_FREE_OK;
            end
         end
         S_M_JOIN: cmd.wr_lo = 1'b1;
         S_DONE:   cmd.rsp_load = !stat.rsp_busy;
         default: ;
      endcase
   end

endmodule

/* sv/bba_datapath.sv */
// bba_datapath: block table memory, node/merge registers, address checks
// and the response register of the buddy allocator.
// Depends on bba_pkg; sequenced by bba_ctrl.
module bba_datapath #(
   parameter int HEAP_BYTES = 16384,
   parameter int MIN_BLOCK  = 32,
   parameter int ENTRIES    = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  bba_pkg::req_type  req_payload,
   input  logic              csr_valid,
   input  logic [31:0]       csr_data,
   input  bba_pkg::cmd_type  cmd,
   output bba_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bba_pkg::rsp_type  rsp_payload
);
   import bba_pkg::*;

   localparam int LOG_MIN = $clog2(MIN_BLOCK);
   localparam int AW      = $clog2(ENTRIES);
   localparam int EW      = $clog2(HEAP_BYTES) + 1;
   localparam int NW      = ((AW > EW) ? AW : EW) + 1;
   localparam logic [NW-1:0] HEAP_N = NW'(HEAP_BYTES);
   localparam logic [NW-1:0] MIN_N  = NW'(MIN_BLOCK);
   localparam logic [NW-1:0] ENT_N  = NW'(ENTRIES);
   localparam logic [31:0] FREE_LIMIT = 32'(HEAP_BYTES - MIN_BLOCK);
   localparam logic [31:0] ENT_32     = 32'(ENTRIES);
   localparam logic [31:0] MIN_32     = 32'(MIN_BLOCK);
   localparam logic [31:0] HEAP_32    = 32'(HEAP_BYTES);

   logic [EW-1:0] mem [ENTRIES];

   logic          cmd_ff;
   logic          big_ff;
   logic [NW-1:0] need_ff;
   logic [31:0]   addr_ff;
   logic [31:0]   base_ff;
   logic [NW-1:0] lo_ff;
   logic [NW-1:0] bytes_ff;
   logic [EW-1:0] rd_ff;
   logic [AW-1:0] clr_ff;
   rsp_type       pend_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic [31:0]   need_w;
   logic [NW-1:0] rd_n, sz, half, units, mid, buddy, low, high;
   logic          can_split, size_eq;
   logic [31:0]   off, idx32, alloc_addr;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data;

   // raise to the minimum block, flag sizes that can never fit
   assign need_w = (32'(req_payload.request_size) < MIN_32) ? MIN_32
                                                            : 32'(req_payload.request_size);

   assign rd_n  = NW'(rd_ff);
   assign sz    = {rd_n[NW-1:1], 1'b0};
   assign half  = bytes_ff >> 1;
   assign units = bytes_ff >> LOG_MIN;
   assign mid   = lo_ff + (half >> LOG_MIN);
   assign buddy = lo_ff ^ units;
   assign low   = (lo_ff < buddy) ? lo_ff : buddy;
   assign high  = (lo_ff < buddy) ? buddy : lo_ff;

   assign can_split = (half >= MIN_N) && (need_ff <= half) && (mid < ENT_N);
   assign size_eq   = (sz == bytes_ff);

   assign off        = addr_ff - base_ff;
   assign idx32      = off >> LOG_MIN;
   assign alloc_addr = base_ff + (32'(lo_ff) << LOG_MIN);

   always_comb begin
      stat            = '0;
      stat.clr_last   = (clr_ff == AW'(ENTRIES - 1));
      stat.is_free    = (cmd_ff == CMD_FREE);
      stat.too_big    = big_ff;
      stat.free_bad   = (addr_ff < base_ff) || (off > FREE_LIMIT) || (idx32 >= ENT_32);
      stat.take       = size_eq && !rd_ff[0] && !can_split;
      stat.split      = size_eq && !rd_ff[0] && can_split;
      stat.go_down    = (sz != '0) && (sz < bytes_ff) && can_split;
      stat.at_root    = (bytes_ff == HEAP_N);
      stat.is_left    = ((lo_ff & units) == '0);
      stat.entry_zero = (rd_n == '0);
      stat.merge_go   = (bytes_ff < HEAP_N) && (units != '0) &&
                        ((lo_ff & (units - NW'(1))) == '0) && (buddy < ENT_N);
      stat.buddy_eq   = (rd_n == bytes_ff);
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // table write port
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = lo_ff[AW-1:0];
      wr_data = '0;
      if (cmd.clr_step) begin
         wr_addr = clr_ff;
         wr_data = (clr_ff == '0) ? EW'(HEAP_BYTES) : '0;
      end else if (cmd.wr_take) begin
         wr_data = EW'(bytes_ff | NW'(1));
      end else if (cmd.wr_split_lo) begin
         wr_data = EW'(half);
      end else if (cmd.wr_split_mid) begin
         wr_addr = mid[AW-1:0];
         wr_data = EW'(half);
      end else if (cmd.wr_unmark) begin
         wr_data = EW'(sz);
      end else if (cmd.wr_hi) begin
         wr_addr = high[AW-1:0];
      end else if (cmd.wr_lo) begin
         wr_addr = low[AW-1:0];
         wr_data = EW'(bytes_ff << 1);
      end else begin
         wr_en = 1'b0;
      end
   end

   assign rd_en   = cmd.rd_lo || cmd.rd_buddy;
   assign rd_addr = cmd.rd_buddy ? buddy[AW-1:0] : lo_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 32'h2000_1000;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) base_ff <= csr_data;
         if (cmd.clr_step) clr_ff <= clr_ff + AW'(1);
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_payload.command;
         big_ff   <= (need_w > HEAP_32);
         need_ff  <= NW'(need_w);
         addr_ff  <= req_payload.free_address;
         lo_ff    <= '0;
         bytes_ff <= HEAP_N;
      end
      if (cmd.down || cmd.wr_split_mid) bytes_ff <= half;
      if (cmd.back_sib) lo_ff <= lo_ff + units;
      if (cmd.back_up) begin
         lo_ff    <= lo_ff - units;
         bytes_ff <= bytes_ff << 1;
      end
      if (cmd.free_idx) lo_ff <= NW'(idx32);
      if (cmd.wr_unmark) bytes_ff <= sz;
      if (cmd.wr_lo) begin
         lo_ff    <= low;
         bytes_ff <= bytes_ff << 1;
      end
      if (cmd.finish) begin
         case (cmd.fin)
            FIN_ALLOC_OK: begin
               pend_ff.status        <= ST_OK;
               pend_ff.block_address <= alloc_addr;
            end
            FIN_FREE_OK: begin
               pend_ff.status        <= ST_OK;
               pend_ff.block_address <= addr_ff;
            end
            FIN_NO_SPACE: begin
               pend_ff.status        <= ST_NO_SPACE;
               pend_ff.block_address <= '0;
            end
            default: begin
               pend_ff.status        <= ST_BAD_ADDR;
               pend_ff.block_address <= '0;
            end
         endcase
      end
      if (cmd.rsp_load) rsp_ff <= pend_ff;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // at most one table write per cycle
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.wr_take, cmd.wr_split_lo, cmd.wr_split_mid,
                cmd.wr_unmark, cmd.wr_hi, cmd.wr_lo}))
      else $error("more than one table write in a cycle");

   // only a free node is handed out
   a_take_free: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_take |-> !rd_ff[0])
      else $error("allocated block was already in use");

   // merge only with an equal free buddy
   a_merge_eq: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_hi |-> (rd_n == bytes_ff))
      else $error("merge with unequal buddy");

   // a pending response never overwrites one still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overrun");
`endif

endmodule
